@@ design/bounded_deque_with_search_assert.svh @@
// Assertion macros for the bounded deque with search.
// With SYNTHESIS defined the macros expand to nothing.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define BDQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bdq assertion failed");

// Checked on every clock edge, also during reset.
`define BDQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("bdq invariant failed");

`else

`define BDQ_ASSERT(lbl, prop)
`define BDQ_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ design/bdq_pkg.sv @@
`default_nettype none

package bdq_pkg;

  // Ring geometry.
  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths.
  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int LEN_W = 7;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4
  } bdq_op_e;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } bdq_state_e;

  // Ring index plus an offset below DEPTH, wrapped with one compare and subtract.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] offs);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Ring index minus one.
  function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] idx);
    logic [PTR_W-1:0] res;
    if (idx == '0) begin
      res = PTR_W'(DEPTH - 1);
    end else begin
      res = idx - 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ design/bounded_deque_with_search.sv @@
// Channel   Handshake             Payload
// ------    --------------------  -----------------------------------
// item in   start / busy          opcode_i, value_i
// result    done_o (one cycle)    ok_o, length_o
//
// Inserts, removals, unused codes and a search of an empty store give their
// result in the cycle after the item is taken, and busy stays low.
// A search of a nonempty store reads the ring one entry per cycle through the
// single registered read port and compares in one shared comparator, with busy
// high meanwhile.
// Reset clears the state, pointers, count and read and result flags; the entry memory needs no clearing.
// The receiver cannot stall: each result is shown for one cycle only.
`include "bounded_deque_with_search_assert.svh"

`default_nettype none

module bounded_deque_with_search import bdq_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [OP_W-1:0]         opcode_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  output logic                         done_o,
  output logic                         ok_o,
  output logic [LEN_W-1:0]             length_o
);

  // Entry memory: one write port, one registered read port.
  logic signed [VAL_W-1:0] mem_q [DEPTH];

  bdq_state_e              state_q, state_d;
  logic [PTR_W-1:0]        front_q, front_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        cursor_q, cursor_d;
  logic signed [VAL_W-1:0] key_q, key_d;
  logic signed [VAL_W-1:0] rd_data_q;
  logic                    rd_vld_q, rd_last_q;
  logic                    done_q, done_d;
  logic                    ok_q, ok_d;
  logic [LEN_W-1:0]        len_q, len_d;

  logic             accept;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic             hit;
  logic             finish;

  assign accept = start && !busy;
  assign busy   = (state_q == ST_SCAN);
  assign hit    = rd_vld_q && (rd_data_q == key_q);
  assign finish = rd_vld_q && (hit || rd_last_q);
  assign rd_addr = ring_add(front_q, cursor_q[PTR_W-1:0]);

  // Next state, memory write and result.
  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    key_d    = key_q;
    done_d   = 1'b0;
    ok_d     = ok_q;
    len_d    = len_q;
    wr_en    = 1'b0;
    wr_addr  = ring_add(front_q, count_q[PTR_W-1:0]);
    rd_en    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          ok_d   = 1'b0;
          unique case (opcode_i)
            OP_PUSH_FRONT: begin
              if (count_q < CNT_W'(DEPTH)) begin
                front_d = ring_dec(front_q);
                wr_en   = 1'b1;
                wr_addr = ring_dec(front_q);
                count_d = count_q + 1'b1;
                ok_d    = 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (count_q < CNT_W'(DEPTH)) begin
                wr_en   = 1'b1;
                count_d = count_q + 1'b1;
                ok_d    = 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (count_q != '0) begin
                front_d = ring_add(front_q, PTR_W'(1));
                count_d = count_q - 1'b1;
                ok_d    = 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (count_q != '0) begin
                count_d = count_q - 1'b1;
                ok_d    = 1'b1;
              end
            end
            OP_SEARCH: begin
              // An empty store answers at once with not found.
              if (count_q != '0) begin
                done_d   = 1'b0;
                state_d  = ST_SCAN;
                cursor_d = '0;
                key_d    = value_i;
              end
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
          len_d = LEN_W'(count_d);
        end
      end
      ST_SCAN: begin
        // Stop on the first match or after the last live entry is compared.
        if (finish) begin
          done_d  = 1'b1;
          ok_d    = hit;
          len_d   = LEN_W'(count_q);
          state_d = ST_IDLE;
        end else if (cursor_q < count_q) begin
          rd_en    = 1'b1;
          cursor_d = cursor_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      front_q   <= '0;
      count_q   <= '0;
      cursor_q  <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      count_q   <= count_d;
      cursor_q  <= cursor_d;
      rd_vld_q  <= rd_en;
      rd_last_q <= rd_en && (cursor_q == count_q - 1'b1);
      done_q    <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    ok_q  <= ok_d;
    len_q <= len_d;
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign done_o   = done_q;
  assign ok_o     = ok_q;
  assign length_o = len_q;

  // The count never exceeds the ring size; while reset is low it is being cleared.
  `BDQ_ASSERT_ALWAYS(a_count_bound, !rst_ni || (count_q <= CNT_W'(DEPTH)))
  // A result never appears while a search is still running.
  `BDQ_ASSERT(a_done_idle, done_q |-> !busy)
  // Read data only comes back while the scan is active.
  `BDQ_ASSERT(a_read_in_scan, rd_vld_q |-> (state_q == ST_SCAN))
  // Every non-search item answers in the next cycle.
  `BDQ_ASSERT(a_quick_result, (accept && (opcode_i != OP_SEARCH)) |=> done_q)

endmodule

`default_nettype wire

@@ test/bounded_deque_with_search_check.sv @@
`default_nettype none

module bounded_deque_with_search_check import bdq_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  input  wire logic                    busy,
  input  wire logic [OP_W-1:0]         opcode_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  input  wire logic                    done_o,
  input  wire logic                    ok_o,
  input  wire logic [LEN_W-1:0]        length_o,
  output int                           fail_count_o,
  output int                           pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             ok;
    logic [LEN_W-1:0] length;
  } deque_result_t;

  // Shadow copy of the deque: ring storage, front index and fill level.
  logic [VAL_W-1:0] shadow_ring [DEPTH];
  int               shadow_front;
  int               shadow_fill;

  // Results owed by the block, oldest first.
  deque_result_t    owed_results_q [$];

  // Applies one operation to the shadow deque and returns the result it should give.
  function automatic deque_result_t apply_deque_op(input logic [OP_W-1:0]  op,
                                                    input logic [VAL_W-1:0] val);
    deque_result_t res;
    int            slot;
    res.ok = 1'b0;
    case (op)
      OP_PUSH_FRONT: begin
        if (shadow_fill < DEPTH) begin
          shadow_front = (shadow_front == 0) ? DEPTH - 1 : shadow_front - 1;
          shadow_ring[shadow_front] = val;
          shadow_fill++;
          res.ok = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_fill < DEPTH) begin
          slot = (shadow_front + shadow_fill) % DEPTH;
          shadow_ring[slot] = val;
          shadow_fill++;
          res.ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_fill > 0) begin
          shadow_front = (shadow_front + 1) % DEPTH;
          shadow_fill--;
          res.ok = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (shadow_fill > 0) begin
          shadow_fill--;
          res.ok = 1'b1;
        end
      end
      OP_SEARCH: begin
        // Only live entries take part in the search.
        for (int i = 0; i < shadow_fill; i++) begin
          slot = (shadow_front + i) % DEPTH;
          if (shadow_ring[slot] == val) begin
            res.ok = 1'b1;
          end
        end
      end
      default: begin
        // Unused codes change nothing and report failure.
      end
    endcase
    res.length = LEN_W'(shadow_fill);
    return res;
  endfunction

  // Compare each result with the oldest owed one, then predict for a taken item.
  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t want;
    int            errs;
    errs = 0;
    if (!rst_ni) begin
      shadow_front = 0;
      shadow_fill  = 0;
      owed_results_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if ($isunknown(done_o)) begin
        $error("done_o is unknown");
        errs++;
      end else if (done_o) begin
        if (owed_results_q.size() == 0) begin
          $error("result with no item waiting: ok %0b, length %0d", ok_o, length_o);
          errs++;
        end else begin
          want = owed_results_q.pop_front();
          if (ok_o !== want.ok) begin
            $error("ok mismatch: expected %0b, actual %0b", want.ok, ok_o);
            errs++;
          end
          if (length_o !== want.length) begin
            $error("length mismatch: expected %0d, actual %0d", want.length, length_o);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        owed_results_q.push_back(apply_deque_op(opcode_i, value_i));
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= owed_results_q.size();
    end
  end

endmodule

`default_nettype wire

@@ test/bounded_deque_with_search_tb.sv @@
`default_nettype none

module bounded_deque_with_search_tb;
  import bdq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 525;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [OP_W-1:0]         opcode_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    done_o;
  logic                    ok_o;
  logic [LEN_W-1:0]        length_o;
  int                      fail_count;
  int                      pending;

  // Rough fill level, used only to steer the random operations.
  int                      level_guess;
  int                      idle_pct;
  logic [VAL_W-1:0]        value_pool [8];

  bounded_deque_with_search dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .opcode_i (opcode_i),
    .value_i  (value_i),
    .done_o   (done_o),
    .ok_o     (ok_o),
    .length_o (length_o)
  );

  bounded_deque_with_search_check checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .ok_o         (ok_o),
    .length_o     (length_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Presents one item and holds it until the block takes it.
  task automatic issue_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val);
    logic taken;
    start    <= 1'b1;
    opcode_i <= op;
    value_i  <= val;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
    if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && level_guess < DEPTH) begin
      level_guess++;
    end else if ((op == OP_POP_FRONT || op == OP_POP_BACK) && level_guess > 0) begin
      level_guess--;
    end
  endtask

  // Leaves the item channel quiet for a random number of cycles.
  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start    <= 1'b0;
      opcode_i <= OP_W'($urandom);
      value_i  <= $urandom;
      @(posedge clk_i);
    end
  endtask

  // Half the time values from a small pool so that searches hit, else any pattern.
  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(9) < 5) begin
      return value_pool[$urandom_range(7)];
    end
    return $urandom;
  endfunction

  // Reset, directed items, random items, then drain and verdict.
  initial begin
    logic [OP_W-1:0] op;
    logic            filling;
    int              sent;
    int              waited;
    int              roll;
    rst_ni      = 1'b0;
    start       = 1'b0;
    opcode_i    = '0;
    value_i     = '0;
    level_guess = 0;
    filling     = 1'b1;
    sent        = 0;
    waited      = 0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < 8; i++) begin
      value_pool[i] = $urandom;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty store: search and both removals fail; unused codes do nothing.
    issue_item(OP_SEARCH, 32'h0000_0000);
    issue_item(OP_POP_FRONT, $urandom);
    issue_item(OP_POP_BACK, $urandom);
    issue_item(3'd5, $urandom);
    issue_item(3'd6, $urandom);
    issue_item(3'd7, $urandom);
    // Extreme values at both ends, then searches that hit and miss.
    issue_item(OP_PUSH_FRONT, 32'h8000_0000);
    issue_item(OP_PUSH_BACK, 32'h7FFF_FFFF);
    issue_item(OP_PUSH_FRONT, 32'h0000_0000);
    issue_item(OP_PUSH_BACK, 32'hFFFF_FFFF);
    issue_item(OP_SEARCH, 32'h8000_0000);
    issue_item(OP_SEARCH, 32'h7FFF_FFFF);
    issue_item(OP_SEARCH, 32'h0000_0001);
    issue_item(OP_SEARCH, 32'hFFFF_FFFE);
    // Removed values sit stale in the ring and must not be found.
    issue_item(OP_POP_FRONT, $urandom);
    issue_item(OP_SEARCH, 32'h0000_0000);
    issue_item(OP_POP_BACK, $urandom);
    issue_item(OP_SEARCH, 32'hFFFF_FFFF);
    issue_item(3'd5, 32'h8000_0000);
    issue_item(OP_POP_FRONT, $urandom);
    issue_item(OP_POP_BACK, $urandom);
    issue_item(OP_PUSH_BACK, 32'h5555_5555);
    issue_item(OP_PUSH_FRONT, 32'hAAAA_AAAA);
    issue_item(OP_SEARCH, 32'h5555_5555);

    // Random part: alternate between filling to full and draining to empty.
    while (sent < RANDOM_ITEMS) begin
      case (sent * 4 / RANDOM_ITEMS)
        0:       idle_pct = 0;
        1:       idle_pct = 86;
        2:       idle_pct = 0;
        default: idle_pct = 24;
      endcase
      idle_gap(idle_pct);
      if (filling && level_guess >= DEPTH && $urandom_range(3) == 0) begin
        filling = 1'b0;
      end else if (!filling && level_guess == 0 && $urandom_range(3) == 0) begin
        filling = 1'b1;
      end else if ($urandom_range(99) < 2) begin
        filling = !filling;
      end
      roll = $urandom_range(99);
      if (roll < 5) begin
        op = OP_W'($urandom_range(7, 5));
      end else if (roll < 22) begin
        op = OP_SEARCH;
      end else if ((roll < 85) == filling) begin
        op = ($urandom_range(1) == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
        op = ($urandom_range(1) == 0) ? OP_POP_FRONT : OP_POP_BACK;
      end
      issue_item(op, pick_value());
      if (op <= OP_SEARCH) begin
        sent++;
      end
    end
    start <= 1'b0;

    // Wait for every owed result, then a margin for stray ones.
    while (pending != 0 && waited < 100_000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DEPTH + 16) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
